// ===== hw/rtl/ltnsg_pkg.sv =====
// Shared types and constants of the latched tone/noise sound generator.
// Holds the command codes, the decay curve constants and the ROM port structs.
// No dependencies.
package ltnsg_pkg;

  // Field widths.
  localparam int unsigned LEVEL_W   = 15;
  localparam int unsigned ROM_AW    = 15;
  localparam int unsigned MODE_W    = 4;
  localparam int unsigned PHASE_W   = 7;
  localparam int unsigned NOISE_W   = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned LATCH_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Full volume is both the top curve address and the top level.
  localparam logic [ROM_AW-1:0] FULL_VOLUME = '1;

  // Register defaults and the default period width.
  localparam int unsigned DEFAULT_PERIOD_BITS = 16;
  localparam int unsigned FAST_PERIOD_RESET   = 79;
  localparam int unsigned SLOW_PERIOD_RESET   = 163;

  // Fixed-point curve: exp(-1/4096) in unsigned Q2.62 from its Taylor series,
  // each term truncated.
  localparam logic [63:0] Q_ONE      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] CURVE_T1   = Q_ONE / 64'd4096;
  localparam logic [63:0] CURVE_T2   = CURVE_T1 / 64'd8192;
  localparam logic [63:0] CURVE_T3   = CURVE_T2 / 64'd12288;
  localparam logic [63:0] CURVE_T4   = CURVE_T3 / 64'd16384;
  localparam logic [63:0] CURVE_T5   = CURVE_T4 / 64'd20480;
  localparam logic [63:0] CURVE_T6   = CURVE_T5 / 64'd24576;
  localparam logic [63:0] CURVE_T7   = CURVE_T6 / 64'd28672;
  localparam logic [63:0] CURVE_RATIO = Q_ONE - CURVE_T1 + CURVE_T2 - CURVE_T3
                                      + CURVE_T4 - CURVE_T5 + CURVE_T6 - CURVE_T7;

  // Input commands; the fourth code is ignored.
  typedef enum logic [CMD_W-1:0] {
    CMD_LATCH  = 2'd0,
    CMD_DECAY  = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_t;

  // Sound source picked by the low three latch bits.
  typedef enum logic [2:0] {
    SRC_PHASE2, SRC_PHASE3, SRC_PHASE4, SRC_PHASE5,
    SRC_GATE04, SRC_GATE15, SRC_GATE26, SRC_NOISE
  } source_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_PERIOD = 1'b0,
    CFG_SLOW_PERIOD = 1'b1
  } cfg_reg_t;

  // Curve builder states.
  typedef enum logic {
    BLD_RUN,
    BLD_DONE
  } build_state_t;

  // Curve ROM write and read requests.
  typedef struct packed {
    logic               we;
    logic [ROM_AW-1:0]  addr;
    logic [LEVEL_W-1:0] data;
  } rom_wr_t;

  typedef struct packed {
    logic              re;
    logic [ROM_AW-1:0] addr;
  } rom_rd_t;

endpackage

// ===== hw/rtl/latched_tone_noise_sound_generator.sv =====
// Top level of the latched tone/noise sound generator.
// Depends on ltnsg_pkg, ltnsg_curve_builder, ltnsg_curve_rom and ltnsg_voice.
//
// After reset the block builds its 32768-entry exponential decay curve in
// its internal memory, one entry at a time through one shared 32x32
// multiplier; in_ready stays low during that pass, while configuration
// writes are taken as ever. From then on a latch write, decay tick or
// sample tick is accepted each cycle that the result register is empty or
// being read, and a sample tick delivers its result in the cycle after
// acceptance.
// Only sample ticks produce a result; it is the level computed at the
// previous sample tick, read from the curve at the volume of that time.
module latched_tone_noise_sound_generator
  import ltnsg_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = DEFAULT_PERIOD_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PERIOD_BITS-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [LATCH_W-1:0]     in_latch_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LEVEL_W-1:0]     out_sample
);

  rom_wr_t            rom_wr;
  rom_rd_t            rom_rd;
  logic [LEVEL_W-1:0] rom_data;
  logic               build_done;
  logic               in_acc;

  // Take a beat once the curve is built and the result slot is free or being read.
  assign in_ready = build_done && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  ltnsg_curve_builder u_builder (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rom_wr),
    .done  (build_done)
  );

  ltnsg_curve_rom u_rom (
    .clk     (clk),
    .wr      (rom_wr),
    .rd      (rom_rd),
    .rd_data (rom_data)
  );

  ltnsg_voice #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_voice (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_acc        (in_acc),
    .in_cmd        (in_cmd),
    .in_latch_data (in_latch_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_sample    (out_sample),
    .rom_rd        (rom_rd),
    .rom_data      (rom_data)
  );

endmodule

// ===== hw/rtl/ltnsg_curve_rom.sv =====
// Decay curve memory: one write port for the build pass, one registered read port.
// Depends on ltnsg_pkg.
module ltnsg_curve_rom
  import ltnsg_pkg::*;
(
  input  logic               clk,
  input  rom_wr_t            wr,
  input  rom_rd_t            rd,
  output logic [LEVEL_W-1:0] rd_data
);

  localparam int unsigned DEPTH = 1 << ROM_AW;

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [LEVEL_W-1:0] rd_data_r;

  // Write port, driven by the builder after reset.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ltnsg_curve_builder.sv =====
// Fills the decay curve memory after reset by repeated Q2.62 multiplication.
// Depends on ltnsg_pkg; drives the write port of ltnsg_curve_rom.
module ltnsg_curve_builder
  import ltnsg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  output rom_wr_t wr,
  output logic    done
);

  localparam logic [2:0] STEP_LAST = 3'd5;

  build_state_t       state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [ROM_AW-1:0]  addr_r, addr_nxt;
  logic [62:0]        power_r, power_nxt;
  logic [63:0]        pp_r;
  logic [1:0]         pp_sh_r;
  logic [125:0]       acc_r, acc_nxt;
  logic [31:0]        mul_a, mul_b;
  logic [125:0]       addend;
  logic [77:0]        scaled;

  // Next state: stop after the lowest address has been written.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BLD_RUN: begin
        if (step_r == STEP_LAST && addr_r == '0) begin
          state_nxt = BLD_DONE;
        end
      end
      BLD_DONE: state_nxt = BLD_DONE;
      default:  state_nxt = BLD_RUN;
    endcase
  end

  // Outputs: one curve entry is written at the first step of each round.
  // The entry is power * 32767 >> 62, taken as (power << 15) - power.
  assign scaled = {power_r, 15'd0} - {15'd0, power_r};

  always_comb begin
    wr.addr = addr_r;
    wr.data = scaled[76:62];
    wr.we   = 1'b0;
    done    = 1'b0;
    unique case (state_r)
      BLD_RUN:  wr.we = (step_r == 3'd0);
      BLD_DONE: done  = 1'b1;
      default:  done  = 1'b0;
    endcase
  end

  // Shared 32x32 multiplier: steps 0..3 take the four partial products.
  always_comb begin
    mul_a = step_r[1] ? {1'b0, power_r[62:32]} : power_r[31:0];
    mul_b = step_r[0] ? CURVE_RATIO[63:32] : CURVE_RATIO[31:0];
  end

  always_ff @(posedge clk) begin
    pp_r    <= mul_a * mul_b;
    pp_sh_r <= {step_r == 3'd3, step_r == 3'd1 || step_r == 3'd2};
  end

  // Accumulate the registered partial products in steps 1..4.
  always_comb begin
    addend = 126'(pp_r);
    if (pp_sh_r[1]) begin
      addend = addend << 64;
    end else if (pp_sh_r[0]) begin
      addend = addend << 32;
    end
    acc_nxt = acc_r;
    case (step_r)
      3'd1:       acc_nxt = addend;
      3'd2, 3'd3,
      3'd4:       acc_nxt = acc_r + addend;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Step sequencing, power update and address countdown.
  always_comb begin
    step_nxt  = step_r;
    addr_nxt  = addr_r;
    power_nxt = power_r;
    if (state_r == BLD_RUN) begin
      if (step_r == STEP_LAST) begin
        step_nxt  = 3'd0;
        addr_nxt  = addr_r - 1'b1;
        power_nxt = acc_r[124:62];
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_RUN;
      step_r  <= 3'd0;
      addr_r  <= FULL_VOLUME;
      power_r <= Q_ONE[62:0];
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      addr_r  <= addr_nxt;
      power_r <= power_nxt;
    end
  end

endmodule

// ===== hw/rtl/ltnsg_voice.sv =====
// Command decode, decay prescaler, phase and noise sources, and the result register.
// Depends on ltnsg_pkg; reads the curve through ltnsg_curve_rom.
module ltnsg_voice
  import ltnsg_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = DEFAULT_PERIOD_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PERIOD_BITS-1:0] cfg_wdata,
  input  logic                   in_acc,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [LATCH_W-1:0]     in_latch_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [LEVEL_W-1:0]     out_sample,
  output rom_rd_t                rom_rd,
  input  logic [LEVEL_W-1:0]     rom_data
);

  logic [PERIOD_BITS-1:0] fast_period_r, slow_period_r;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [ROM_AW-1:0]      volume_r, volume_nxt;
  logic [NOISE_W-1:0]     noise_r, noise_nxt;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [PERIOD_BITS-1:0] prescale_r, prescale_nxt;
  logic                   gate_r, gate_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]     out_sample_r;
  logic [PERIOD_BITS-1:0] period;
  logic [PERIOD_BITS-1:0] prescale_inc;
  logic [PHASE_W-1:0]     phase_inc;
  logic [NOISE_W-1:0]     noise_step;
  logic                   noise_feed;
  logic                   source_hi;
  logic                   is_sample;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_period_r <= PERIOD_BITS'(FAST_PERIOD_RESET);
      slow_period_r <= PERIOD_BITS'(SLOW_PERIOD_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FAST_PERIOD: fast_period_r <= cfg_wdata;
        CFG_SLOW_PERIOD: slow_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decay prescaler; a zero period steps on every tick.
  assign period       = mode_r[3] ? fast_period_r : slow_period_r;
  assign prescale_inc = prescale_r + 1'b1;

  // Phase advance and noise shift for a sample beat.
  assign phase_inc  = phase_r + 1'b1;
  assign noise_feed = (noise_r[0] == noise_r[10]);
  assign noise_step = (phase_inc[1:0] == 2'd2) ? {noise_r[NOISE_W-2:0], noise_feed}
                                               : noise_r;

  // Source select on the advanced phase and noise.
  always_comb begin
    case (source_t'(mode_r[2:0]))
      SRC_PHASE2: source_hi = phase_inc[2];
      SRC_PHASE3: source_hi = phase_inc[3];
      SRC_PHASE4: source_hi = phase_inc[4];
      SRC_PHASE5: source_hi = phase_inc[5];
      SRC_GATE04: source_hi = !phase_inc[0] && !phase_inc[4];
      SRC_GATE15: source_hi = !phase_inc[1] && !phase_inc[5];
      SRC_GATE26: source_hi = !phase_inc[2] && !phase_inc[6];
      default:    source_hi = noise_step[NOISE_W-1];
    endcase
  end

  // Command decode.
  always_comb begin
    mode_nxt     = mode_r;
    volume_nxt   = volume_r;
    noise_nxt    = noise_r;
    phase_nxt    = phase_r;
    prescale_nxt = prescale_r;
    gate_nxt     = gate_r;
    is_sample    = 1'b0;
    if (in_acc) begin
      unique case (in_cmd)
        CMD_LATCH: begin
          mode_nxt     = in_latch_data[MODE_W-1:0];
          volume_nxt   = FULL_VOLUME;
          noise_nxt    = '0;
          prescale_nxt = '0;
        end
        CMD_DECAY: begin
          prescale_nxt = prescale_inc;
          if (prescale_inc >= period) begin
            prescale_nxt = '0;
            if (volume_r != '0) begin
              volume_nxt = volume_r - 1'b1;
            end
          end
        end
        CMD_SAMPLE: begin
          is_sample = 1'b1;
          phase_nxt = phase_inc;
          noise_nxt = noise_step;
          gate_nxt  = source_hi;
        end
        default: ;
      endcase
    end
  end

  // The curve entry for the next level is read at the current volume.
  assign rom_rd.re   = is_sample;
  assign rom_rd.addr = volume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= '0;
      volume_r   <= '0;
      noise_r    <= '0;
      phase_r    <= '0;
      prescale_r <= '0;
      gate_r     <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      volume_r   <= volume_nxt;
      noise_r    <= noise_nxt;
      phase_r    <= phase_nxt;
      prescale_r <= prescale_nxt;
      gate_r     <= gate_nxt;
    end
  end

  // Result register: a sample beat emits the level held since the last one.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (is_sample) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      out_sample_r <= gate_r ? rom_data : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // A result appears only after a sample beat.
  a_valid_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_cmd == CMD_SAMPLE))
    else $error("result raised without a sample beat");

  // A latch write restores full volume.
  a_latch_full_volume: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_LATCH |=> volume_r == FULL_VOLUME)
    else $error("volume not full after latch write");

  // The noise shifter moves only on sample or latch beats.
  a_noise_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_cmd == CMD_SAMPLE || in_cmd == CMD_LATCH)) |=> $stable(noise_r))
    else $error("noise shifter changed without a sample or latch beat");

  // Volume never rises except through a latch write.
  a_volume_falls: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_cmd == CMD_LATCH) |=> volume_r <= $past(volume_r))
    else $error("volume rose without a latch write");

endmodule
